// ===== design/lru_pkg.sv =====
// Shared constants for the LRU page replacement block.
`default_nettype none

package lru_pkg;

    localparam int DEF_MAX_FRAMES = 8;
    localparam int DEF_PAGE_BITS  = 16;

    localparam int CFG_W          = 4;
    localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

    localparam int FRAME_IDX_W    = 3;
    localparam int COUNT_W        = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

// ===== design/lru_page_replacement.sv =====
// Top level of the LRU page replacement engine: frame table, scan sequencer, result register.
`default_nettype none

// LRU page replacement over a table of MAX_FRAMES page frames.
//
// Input: a page reference word (page_number) is accepted on a rising edge
// with start high and busy low. busy rises on the next cycle and stays high
// until the result word is issued.
// Config: frames_in_use is written via cfg_we / cfg_wdata; the user must write it only while
// idle, the block does not enforce it. Zero acts as one frame, over MAX_FRAMES as MAX_FRAMES.
// Output: exactly one result word per reference, shown for one cycle with
// done high. The receiver cannot stall; the word is gone after that cycle.
//
// Sequence: after the accepting edge, one frame is read per cycle from the frame
// memories through a single shared compare unit (page match and oldest-stamp
// search), then a drain state completes the last read and an update state loads
// the victim and forms the result. busy is low in the done cycle, so the next
// reference can be taken there; a new reference is never taken while one is
// still being scanned.
//
// Reset: all frames invalid, time and fault counters zero, frames_in_use 8.
// Invalid frames read as stamp zero, so empty frames fill in index order.
module lru_page_replacement #(
    parameter int MAX_FRAMES = lru_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lru_pkg::DEF_PAGE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [PAGE_BITS-1:0]            page_number,
    input  wire logic                            cfg_we,
    input  wire logic [lru_pkg::CFG_W-1:0]       cfg_wdata,
    output logic                                 done,
    output logic                                 hit,
    output logic [lru_pkg::FRAME_IDX_W-1:0]      frame_index,
    output logic                                 evicted_valid,
    output logic [PAGE_BITS-1:0]                 evicted_page,
    output logic [lru_pkg::COUNT_W-1:0]          fault_count
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW    = lru_pkg::COUNT_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_UPDATE} state_t;

    state_t                      state_reg;
    logic [lru_pkg::CFG_W-1:0]   fiu_reg;
    logic [CW-1:0]               time_reg;
    logic [CW-1:0]               fault_reg;
    logic [MAX_FRAMES-1:0]       frame_valid_reg;
    logic [PAGE_BITS-1:0]        page_reg;
    logic [IDX_W-1:0]            scan_idx_reg;

    // check stage: one frame's registered read data
    logic                        chk_live_reg;
    logic [IDX_W-1:0]            chk_idx_reg;
    logic                        vld_rd_reg;
    logic [PAGE_BITS-1:0]        page_rd_reg;
    logic [CW-1:0]               use_rd_reg;

    // search results
    logic                        found_reg;
    logic [IDX_W-1:0]            chosen_reg;
    logic [IDX_W-1:0]            victim_reg;
    logic [CW-1:0]               min_reg;
    logic                        vic_valid_reg;
    logic [PAGE_BITS-1:0]        vic_page_reg;

    // result word
    logic                        busy_reg;
    logic                        done_reg;
    logic                        hit_reg;
    logic [lru_pkg::FRAME_IDX_W-1:0] frame_index_reg;
    logic                        ev_valid_reg;
    logic [PAGE_BITS-1:0]        ev_page_reg;
    logic [CW-1:0]               fault_count_reg;

    // frame memories; contents only meaningful where the valid bit is set
    logic [PAGE_BITS-1:0]        frame_page_mem [MAX_FRAMES];
    logic [CW-1:0]               last_use_mem   [MAX_FRAMES];

    logic                        accept;
    logic [IDX_W-1:0]            last_idx;
    logic [CW-1:0]               time_next;
    logic [CW-1:0]               fault_next;
    logic [CW-1:0]               use_val;
    logic                        chk_match;
    logic                        take_victim;
    logic                        miss_load;
    logic                        use_we;
    logic [IDX_W-1:0]            use_waddr;

    assign accept = start && !busy_reg;

    // last active frame index after clamping frames_in_use
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(fiu_reg) >= MAX_FRAMES)
        begin
            last_idx = IDX_W'(MAX_FRAMES - 1);
        end
        else
        begin
            last_idx = IDX_W'(32'(fiu_reg) - 32'd1);
        end
    end

    assign time_next  = (time_reg == lru_pkg::COUNT_MAX) ? time_reg : time_reg + 1'b1;
    assign fault_next = (found_reg || fault_reg == lru_pkg::COUNT_MAX) ?
                        fault_reg : fault_reg + 1'b1;

    // shared compare unit: match and oldest-stamp test on one frame
    assign use_val     = vld_rd_reg ? use_rd_reg : '0;
    assign chk_match   = chk_live_reg && vld_rd_reg && (page_rd_reg == page_reg);
    assign take_victim = chk_live_reg && ((chk_idx_reg == '0) || (min_reg > use_val));

    assign miss_load = (state_reg == S_UPDATE) && !found_reg;
    assign use_we    = chk_match || miss_load;
    assign use_waddr = chk_match ? chk_idx_reg : victim_reg;

    // frame memories: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (use_we)
        begin
            last_use_mem[use_waddr] <= time_reg;
        end
        if (miss_load)
        begin
            frame_page_mem[victim_reg] <= page_reg;
        end
        page_rd_reg <= frame_page_mem[scan_idx_reg];
        use_rd_reg  <= last_use_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fiu_reg         <= lru_pkg::FRAMES_RESET;
            time_reg        <= '0;
            fault_reg       <= '0;
            frame_valid_reg <= '0;
            scan_idx_reg    <= '0;
            chk_live_reg    <= 1'b0;
            chk_idx_reg     <= '0;
            vld_rd_reg      <= 1'b0;
            found_reg       <= 1'b0;
            chosen_reg      <= '0;
            victim_reg      <= '0;
            min_reg         <= '0;
            vic_valid_reg   <= 1'b0;
            vic_page_reg    <= '0;
            page_reg        <= '0;
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            frame_index_reg <= '0;
            ev_valid_reg    <= 1'b0;
            ev_page_reg     <= '0;
            fault_count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_we)
            begin
                fiu_reg <= cfg_wdata;
            end

            // check stage, works on each read's registered data in the following cycle
            if (chk_match && !found_reg)
            begin
                found_reg  <= 1'b1;
                chosen_reg <= chk_idx_reg;
            end
            if (take_victim)
            begin
                victim_reg    <= chk_idx_reg;
                min_reg       <= use_val;
                vic_valid_reg <= vld_rd_reg;
                vic_page_reg  <= page_rd_reg;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        page_reg     <= page_number;
                        time_reg     <= time_next;
                        scan_idx_reg <= '0;
                        found_reg    <= 1'b0;
                        busy_reg     <= 1'b1;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    chk_live_reg <= 1'b1;
                    chk_idx_reg  <= scan_idx_reg;
                    vld_rd_reg   <= frame_valid_reg[scan_idx_reg];
                    if (scan_idx_reg == last_idx)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    chk_live_reg <= 1'b0;
                    state_reg    <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (!found_reg)
                    begin
                        frame_valid_reg[victim_reg] <= 1'b1;
                    end
                    fault_reg       <= fault_next;
                    done_reg        <= 1'b1;
                    hit_reg         <= found_reg;
                    frame_index_reg <= lru_pkg::FRAME_IDX_W'(found_reg ? chosen_reg
                                                                       : victim_reg);
                    ev_valid_reg    <= !found_reg && vic_valid_reg;
                    ev_page_reg     <= (!found_reg && vic_valid_reg) ? vic_page_reg : '0;
                    fault_count_reg <= fault_next;
                    busy_reg        <= 1'b0;
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = fault_count_reg;

endmodule

`default_nettype wire

// ===== design/lru_chk.sv =====
// Port-level checker for the LRU page replacement block, with its bind.
`default_nettype none

module lru_chk #(
    parameter int PAGE_BITS = lru_pkg::DEF_PAGE_BITS
) (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       done,
    input wire logic                       hit,
    input wire logic                       evicted_valid,
    input wire logic [PAGE_BITS-1:0]       evicted_page,
    input wire logic [lru_pkg::COUNT_W-1:0] fault_count
);

    // accepted word keeps the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // result only issued once the scan is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while busy");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!evicted_valid && evicted_page == '0))
        else $error("eviction reported on hit");

    // fault total only moves with a result word
    a_fault_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(fault_count))
        else $error("fault count changed without result");

endmodule

bind lru_page_replacement lru_chk #(.PAGE_BITS(PAGE_BITS)) u_lru_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the LRU page replacement engine.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lru_pkg::*;

    localparam int NF = DEF_MAX_FRAMES;
    localparam int PW = DEF_PAGE_BITS;

    // Settle margin: longer than the worst-case time for one reference.
    localparam int SETTLE_CYCLES = NF + 8;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 300;
    localparam int POOL_MAX      = 16;

    // One result word, as the block reports it.
    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame;
        logic                   ev_valid;
        logic [PW-1:0]          ev_page;
        logic [COUNT_W-1:0]     faults;
    } lookup_word_t;

    // One directed stimulus row: optional frame count write, then a reference.
    // When typed is set the expected word is taken from the row itself.
    typedef struct packed {
        logic               wr;
        logic [CFG_W-1:0]   cfg;
        logic [PW-1:0]      page;
        logic               typed;
        lookup_word_t       expected;
    } directed_row_t;

    localparam lookup_word_t NO_WORD = '0;
    localparam int DIR_ROWS = 21;

    localparam directed_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        // from reset: 8 frames, empty frames fill in index order
        '{1'b0, 4'd0,  16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
        '{1'b0, 4'd0,  16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2}},
        '{1'b0, 4'd0,  16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
        '{1'b0, 4'd0,  16'h0001, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 32'd3}},
        '{1'b0, 4'd0,  16'h8000, 1'b1, '{1'b0, 3'd3, 1'b0, 16'h0000, 32'd4}},
        '{1'b0, 4'd0,  16'h5555, 1'b1, '{1'b0, 3'd4, 1'b0, 16'h0000, 32'd5}},
        '{1'b0, 4'd0,  16'hAAAA, 1'b1, '{1'b0, 3'd5, 1'b0, 16'h0000, 32'd6}},
        '{1'b0, 4'd0,  16'h1234, 1'b1, '{1'b0, 3'd6, 1'b0, 16'h0000, 32'd7}},
        '{1'b0, 4'd0,  16'h00FF, 1'b1, '{1'b0, 3'd7, 1'b0, 16'h0000, 32'd8}},
        // table full: evictions of the least recently used frame, then a hit on 8000
        '{1'b0, 4'd0,  16'h7777, 1'b0, NO_WORD},
        '{1'b0, 4'd0,  16'hFFFF, 1'b0, NO_WORD},
        '{1'b0, 4'd0,  16'h8000, 1'b0, NO_WORD},
        // shrink to 2 frames: 5555 sits in an inactive frame, so it misses
        '{1'b1, 4'd2,  16'h5555, 1'b0, NO_WORD},
        // over-range count acts as 8: 5555 now matches twice
        '{1'b1, 4'd15, 16'h5555, 1'b0, NO_WORD},
        '{1'b0, 4'd0,  16'h5555, 1'b0, NO_WORD},
        // zero count acts as one frame
        '{1'b1, 4'd0,  16'hABCD, 1'b0, NO_WORD},
        '{1'b0, 4'd0,  16'hABCD, 1'b0, NO_WORD},
        '{1'b1, 4'd1,  16'h0000, 1'b0, NO_WORD},
        '{1'b1, 4'd9,  16'h0000, 1'b0, NO_WORD},
        '{1'b1, 4'd8,  16'h3C3C, 1'b0, NO_WORD},
        '{1'b0, 4'd0,  16'hC3C3, 1'b0, NO_WORD}
    };

    // Per-phase frame count (the last phase draws a random one) and sender idle percentage.
    localparam logic [CFG_W-1:0] PHASE_FRAMES [PHASES] = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd7, 4'd8};
    localparam int PHASE_IDLE [PHASES] = '{0, 46, 27, 46, 0, 27};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [PW-1:0]          page_number;
    logic                   cfg_we;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   done;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PW-1:0]          evicted_page;
    logic [COUNT_W-1:0]     fault_count;

    // Predictor state: shadow frame table, counters and frame count register.
    logic [PW-1:0]      tbl_page  [NF];
    logic               tbl_valid [NF];
    logic [COUNT_W-1:0] tbl_stamp [NF];
    logic [COUNT_W-1:0] use_clock;
    logic [COUNT_W-1:0] fault_tally;
    logic [CFG_W-1:0]   frames_cfg;

    // Result words still owed by the block, oldest first.
    lookup_word_t expected_words [$];
    lookup_word_t head_word;
    int           mismatches = 0;

    lru_page_replacement #(
        .MAX_FRAMES (NF),
        .PAGE_BITS  (PW)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predict one page reference and advance the shadow state.
    // A hit refreshes every matching active frame; the lowest one is reported.
    // A miss takes the active frame with the oldest stamp (lowest index on ties).
    function automatic lookup_word_t reference_page(input logic [PW-1:0] pg);
        int unsigned  active;
        int unsigned  victim;
        logic         found;
        lookup_word_t w;
        active = (frames_cfg == 0) ? 1 : ((frames_cfg > NF) ? NF : frames_cfg);
        w      = '0;
        found  = 1'b0;
        victim = 0;
        // time stamp saturates; once stuck, all new stamps tie
        if (use_clock != COUNT_MAX)
            use_clock = use_clock + 1'b1;
        for (int k = 0; k < active; k++)
        begin
            if (tbl_valid[k] && tbl_page[k] == pg)
            begin
                if (!found)
                    w.frame = FRAME_IDX_W'(k);
                found        = 1'b1;
                tbl_stamp[k] = use_clock;
            end
        end
        if (!found)
        begin
            for (int k = 1; k < active; k++)
                if (tbl_stamp[victim] > tbl_stamp[k])
                    victim = k;
            // page store is only read for a frame that holds a page
            if (tbl_valid[victim])
            begin
                w.ev_valid = 1'b1;
                w.ev_page  = tbl_page[victim];
            end
            tbl_page[victim]  = pg;
            tbl_valid[victim] = 1'b1;
            tbl_stamp[victim] = use_clock;
            if (fault_tally != COUNT_MAX)
                fault_tally = fault_tally + 1'b1;
            w.frame = FRAME_IDX_W'(victim);
        end
        w.hit    = found;
        w.faults = fault_tally;
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [COUNT_W-1:0] want,
                                 input logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Drive one reference word and return at the edge that accepts it.
    // start stays high afterwards; the next call either keeps it up with a new
    // page or drops it for an idle gap, so start gets one update per step.
    task automatic issue_ref(input logic [PW-1:0] pg, input int idle_pct);
        if ($urandom_range(99) < idle_pct)
            repeat ($urandom_range(14, 1))
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start       <= 1'b1;
        page_number <= pg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Frame count write, only with the block idle: drain all owed words and
    // let a full reference time pass before touching the register.
    task automatic write_frames(input logic [CFG_W-1:0] v);
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        frames_cfg  = v;
    endtask

    // Result checker: done is a one-cycle strobe, sampled at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with no reference outstanding");
                mismatches++;
            end
            else
            begin
                head_word = expected_words.pop_front();
                compare_field("hit", head_word.hit, hit);
                compare_field("frame_index", head_word.frame, frame_index);
                compare_field("evicted_valid", head_word.ev_valid, evicted_valid);
                compare_field("evicted_page", head_word.ev_page, evicted_page);
                compare_field("fault_count", head_word.faults, fault_count);
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin
        logic [PW-1:0] pool [POOL_MAX];
        int            pool_n;
        logic [PW-1:0] pg;
        lookup_word_t  predicted;

        start       <= 1'b0;
        page_number <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        rst_n        = 1'b0;

        // shadow state as after reset
        for (int k = 0; k < NF; k++)
        begin
            tbl_page[k]  = '0;
            tbl_valid[k] = 1'b0;
            tbl_stamp[k] = '0;
        end
        use_clock   = '0;
        fault_tally = '0;
        frames_cfg  = FRAMES_RESET;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset fill order, full-table eviction, count changes
        // mid-stream, out-of-range counts and multiple matches.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].wr)
                write_frames(DIRECTED_ROWS[r].cfg);
            issue_ref(DIRECTED_ROWS[r].page, 0);
            predicted = reference_page(DIRECTED_ROWS[r].page);
            expected_words.push_back(DIRECTED_ROWS[r].typed ? DIRECTED_ROWS[r].expected
                                                            : predicted);
        end

        // Random part: each phase uses a small working set so hits and
        // evictions both happen often, mixed with fully random pages.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_frames((ph == PHASES - 1) ? CFG_W'($urandom_range(15)) : PHASE_FRAMES[ph]);
            pool_n = $urandom_range(POOL_MAX, 2);
            for (int k = 0; k < pool_n; k++)
            begin
                case ($urandom_range(9))
                    0:       pool[k] = '0;
                    1:       pool[k] = '1;
                    default: pool[k] = PW'($urandom);
                endcase
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if ($urandom_range(99) < 70)
                    pg = pool[$urandom_range(pool_n - 1)];
                else
                    pg = PW'($urandom);
                issue_ref(pg, PHASE_IDLE[ph]);
                predicted = reference_page(pg);
                expected_words.push_back(predicted);
            end
        end

        // Drain, then watch a while longer for stray words.
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2)
            @(posedge clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (about 0.4 ms).
    initial
    begin
        #4_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
